### rtl/look_at_view_matrix_defines.svh
// ----------------------------------------------------------------------------
// Look-at view matrix: assertion macros
// Shared assertion wrappers. Define NO_ASSERTIONS to compile them away.
// ----------------------------------------------------------------------------
`ifndef LOOK_AT_VIEW_MATRIX_DEFINES_SVH
`define LOOK_AT_VIEW_MATRIX_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define LAVM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lavm assertion failed");
`define LAVM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lavm assertion failed");
`else
`define LAVM_ASSERT_NOW(lbl, ante, cons)
`define LAVM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### rtl/lavm_pkg.sv
// ----------------------------------------------------------------------------
// Look-at view matrix package
// Fixed-point widths, the shared sideband type and rounding and saturation helpers.
// ----------------------------------------------------------------------------
package lavm_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DW  = 32;                 // data word
  localparam int PRE = 29;                 // normalized magnitude sits in [2^PRE, 2^(PRE+1))
  localparam int MB  = PRE + 1;            // normalized magnitude bits
  localparam int VW  = FRAC_BITS + 34;     // signed vector entering a normalize unit
  localparam int SW  = VW + PRE;           // pre-shifted magnitude width
  localparam int NSH = $clog2(SW - PRE);   // binary right-shift steps
  localparam int SQW = 2 * MB;             // square of a normalized magnitude
  localparam int RW  = 2 * MB + 4;         // square root working width
  localparam int NRT = MB + 1;             // square root steps
  localparam int LW  = MB + 1;             // vector length
  localparam int NW  = MB + FRAC_BITS + 1; // dividend and remainder
  localparam int QW  = FRAC_BITS + 1;      // unit component magnitude
  localparam int OW  = FRAC_BITS + 2;      // signed unit component
  localparam int UW  = FRAC_BITS + 3;      // signed true-up component
  localparam int TW  = FRAC_BITS + 36;     // wide dot and cross sums
  localparam int NEL = 16;
  localparam int IW  = $clog2(NEL);

  localparam logic [TW-1:0] HALF_LSB = TW'(1) << (FRAC_BITS - 1);
  localparam logic [TW-1:0] SAT_HI = {{(TW - DW + 1){1'b0}}, {(DW - 1){1'b1}}};
  localparam logic [TW-1:0] SAT_LO = {{(TW - DW + 1){1'b1}}, {(DW - 1){1'b0}}};
  localparam logic [DW-1:0] ONE_FX = DW'(1) << FRAC_BITS;

  typedef struct packed {
    logic [2:0][DW-1:0] eye;
    logic [2:0][DW-1:0] aux;
  } side_t;

  // Drop FRAC_BITS fraction bits, rounding half away from zero.
  function automatic logic [TW-1:0] rnd_frac(input logic [TW-1:0] v);
    logic [TW-1:0] mag;
    mag = v[TW-1] ? (TW'(0) - v) : v;
    mag = (mag + HALF_LSB) >> FRAC_BITS;
    return v[TW-1] ? (TW'(0) - mag) : mag;
  endfunction

  function automatic logic [DW-1:0] sat_word(input logic [TW-1:0] v);
    logic [DW-1:0] r;
    if ($signed(v) > $signed(SAT_HI)) begin
      r = SAT_HI[DW-1:0];
    end else if ($signed(v) < $signed(SAT_LO)) begin
      r = SAT_LO[DW-1:0];
    end else begin
      r = v[DW-1:0];
    end
    return r;
  endfunction

endpackage

### rtl/lavm_norm.sv
// ----------------------------------------------------------------------------
// Normalize unit
// Pipelined vector normalize: magnitude scaling, sum of squares, one square
// root bit per stage, one quotient bit per stage, sign restore.
// ----------------------------------------------------------------------------
module lavm_norm import lavm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [2:0][VW-1:0] vec,
  input  side_t              in_side,
  output logic               out_valid,
  output logic [2:0][OW-1:0] unit,
  output side_t              out_side
);

  localparam int K_SQR = NSH + 1;
  localparam int K_SUM = NSH + 2;
  localparam int K_RT0 = NSH + 3;
  localparam int K_LEN = K_RT0 + NRT;
  localparam int K_DV0 = K_LEN + 1;
  localparam int K_SGN = K_DV0 + QW;
  localparam int NS    = K_SGN + 2;
  localparam logic [SW-1:0] TOP_LOW = SW'(1) << PRE;

  typedef struct packed {
    side_t              side;
    logic [2:0]         neg;
    logic               zero;
    logic [SW-1:0]      top;
    logic [2:0][SW-1:0] m;
    logic [2:0][SQW-1:0] sq;
    logic [RW-1:0]      n;
    logic [RW-1:0]      r;
    logic [LW-1:0]      len;
    logic [2:0][NW-1:0] rem;
    logic [2:0][QW-1:0] q;
    logic [2:0][OW-1:0] o;
  } nrm_st_t;

  nrm_st_t       p [NS];
  nrm_st_t       first_next;
  logic [NS-1:0] vld;

  // Magnitudes start pre-shifted so that the scaling below only shifts right.
  always_comb begin
    first_next = '0;
    first_next.side = in_side;
    for (int i = 0; i < 3; i++) begin
      first_next.neg[i] = vec[i][VW-1];
      first_next.m[i] = SW'(vec[i][VW-1] ? (VW'(0) - vec[i]) : vec[i]) << PRE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p[0] <= first_next;
    end
  end

  for (genvar k = 0; k < NS - 1; k++) begin : g_stg
    nrm_st_t stage_next;

    if (k == 0) begin : g_max
      logic [SW-1:0] t01;
      assign t01 = (p[k].m[0] > p[k].m[1]) ? p[k].m[0] : p[k].m[1];
      always_comb begin
        stage_next = p[k];
        stage_next.top = (t01 > p[k].m[2]) ? t01 : p[k].m[2];
        stage_next.zero = (stage_next.top == '0);
      end
    end else if (k <= NSH) begin : g_shift
      localparam int AMT = 1 << (NSH - k);
      always_comb begin
        stage_next = p[k];
        if ((p[k].top >> AMT) >= TOP_LOW) begin
          stage_next.top = p[k].top >> AMT;
          for (int i = 0; i < 3; i++) begin
            stage_next.m[i] = p[k].m[i] >> AMT;
          end
        end
      end
    end else if (k == K_SQR) begin : g_sqr
      always_comb begin
        stage_next = p[k];
        for (int i = 0; i < 3; i++) begin
          stage_next.sq[i] = p[k].m[i][MB-1:0] * p[k].m[i][MB-1:0];
        end
      end
    end else if (k == K_SUM) begin : g_sum
      always_comb begin
        stage_next = p[k];
        stage_next.n = RW'(p[k].sq[0]) + RW'(p[k].sq[1]) + RW'(p[k].sq[2]);
        stage_next.r = '0;
      end
    end else if (k < K_LEN) begin : g_root
      localparam logic [RW-1:0] BIT = RW'(1) << (2 * (MB - (k - K_RT0)));
      logic [RW-1:0] trial;
      assign trial = p[k].r + BIT;
      always_comb begin
        stage_next = p[k];
        if (p[k].n >= trial) begin
          stage_next.n = p[k].n - trial;
          stage_next.r = (p[k].r >> 1) + BIT;
        end else begin
          stage_next.r = p[k].r >> 1;
        end
      end
    end else if (k == K_LEN) begin : g_len
      // Dividend is the magnitude in fixed point plus half the length.
      always_comb begin
        stage_next = p[k];
        stage_next.len = p[k].r[LW-1:0];
        stage_next.q = '0;
        for (int i = 0; i < 3; i++) begin
          stage_next.rem[i] = (NW'(p[k].m[i][MB-1:0]) << FRAC_BITS) +
                              NW'(p[k].r[LW-1:1]);
        end
      end
    end else if (k < K_SGN) begin : g_div
      localparam int B = FRAC_BITS - (k - K_DV0);
      logic [NW:0] dsr;
      assign dsr = (NW + 1)'(p[k].len) << B;
      always_comb begin
        stage_next = p[k];
        for (int i = 0; i < 3; i++) begin
          if ({1'b0, p[k].rem[i]} >= dsr) begin
            stage_next.rem[i] = p[k].rem[i] - dsr[NW-1:0];
            stage_next.q[i][B] = 1'b1;
          end
        end
      end
    end else begin : g_sign
      // A zero vector runs through with a zero length and is forced to zero here.
      always_comb begin
        stage_next = p[k];
        for (int i = 0; i < 3; i++) begin
          if (p[k].zero) begin
            stage_next.o[i] = '0;
          end else if (p[k].neg[i]) begin
            stage_next.o[i] = OW'(0) - OW'(p[k].q[i]);
          end else begin
            stage_next.o[i] = OW'(p[k].q[i]);
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        p[k+1] <= stage_next;
      end
    end
  end

  assign out_valid = vld[NS-1];
  assign unit      = p[NS-1].o;
  assign out_side  = p[NS-1].side;

endmodule

### rtl/lavm_xf.sv
// ----------------------------------------------------------------------------
// Side vector cross product
// Forms forward x up in two stages: products, then differences.
// ----------------------------------------------------------------------------
module lavm_xf import lavm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [2:0][OW-1:0] f,
  input  side_t              in_side,
  output logic               out_valid,
  output logic [2:0][VW-1:0] vec,
  output side_t              out_side
);

  logic [5:0][VW-1:0] prod;
  side_t              side1;
  logic [1:0]         vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[0], in_valid};
    end
  end

  // The up vector leaves the sideband here; the forward vector takes its place.
  always_ff @(posedge clk) begin
    if (en) begin
      prod[0] <= $signed(f[1]) * $signed(in_side.aux[2]);
      prod[1] <= $signed(f[2]) * $signed(in_side.aux[1]);
      prod[2] <= $signed(f[2]) * $signed(in_side.aux[0]);
      prod[3] <= $signed(f[0]) * $signed(in_side.aux[2]);
      prod[4] <= $signed(f[0]) * $signed(in_side.aux[1]);
      prod[5] <= $signed(f[1]) * $signed(in_side.aux[0]);
      side1.eye <= in_side.eye;
      for (int i = 0; i < 3; i++) begin
        side1.aux[i] <= DW'($signed(f[i]));
      end
      vec[0]   <= prod[0] - prod[1];
      vec[1]   <= prod[2] - prod[3];
      vec[2]   <= prod[4] - prod[5];
      out_side <= side1;
    end
  end

  assign out_valid = vld[1];

endmodule

### rtl/lavm_mat.sv
// ----------------------------------------------------------------------------
// Matrix assembly
// True-up cross product, translation dot products, rounding and saturation,
// and assembly of all sixteen elements.
// ----------------------------------------------------------------------------
module lavm_mat import lavm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [2:0][OW-1:0]    s,
  input  side_t                 in_side,
  output logic                  out_valid,
  output logic [NEL-1:0][DW-1:0] mat
);

  localparam int NM = 7;

  typedef struct packed {
    logic [2:0][OW-1:0]    s;
    logic [2:0][OW-1:0]    f;
    logic [2:0][DW-1:0]    eye;
    logic [5:0][TW-1:0]    pu;
    logic [2:0][TW-1:0]    ps;
    logic [2:0][TW-1:0]    pf;
    logic [2:0][TW-1:0]    pe;
    logic [2:0][TW-1:0]    cu;
    logic [2:0][UW-1:0]    u;
    logic [TW-1:0]         ds;
    logic [TW-1:0]         df;
    logic [TW-1:0]         de;
    logic [NEL-1:0][DW-1:0] el;
  } mat_st_t;

  mat_st_t            st [1:NM];
  mat_st_t            st_next [1:NM];
  logic [2:0][OW-1:0] f_in;
  logic [NM-1:0]      vld;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      f_in[i] = in_side.aux[i][OW-1:0];
    end
  end

  always_comb begin
    st_next[1] = '0;
    st_next[1].s   = s;
    st_next[1].f   = f_in;
    st_next[1].eye = in_side.eye;
    st_next[1].pu[0] = $signed(s[1]) * $signed(f_in[2]);
    st_next[1].pu[1] = $signed(s[2]) * $signed(f_in[1]);
    st_next[1].pu[2] = $signed(s[2]) * $signed(f_in[0]);
    st_next[1].pu[3] = $signed(s[0]) * $signed(f_in[2]);
    st_next[1].pu[4] = $signed(s[0]) * $signed(f_in[1]);
    st_next[1].pu[5] = $signed(s[1]) * $signed(f_in[0]);
    for (int i = 0; i < 3; i++) begin
      st_next[1].ps[i] = $signed(s[i]) * $signed(in_side.eye[i]);
      st_next[1].pf[i] = $signed(f_in[i]) * $signed(in_side.eye[i]);
    end

    st_next[2] = st[1];
    st_next[2].cu[0] = st[1].pu[0] - st[1].pu[1];
    st_next[2].cu[1] = st[1].pu[2] - st[1].pu[3];
    st_next[2].cu[2] = st[1].pu[4] - st[1].pu[5];
    st_next[2].ds = st[1].ps[0] + st[1].ps[1] + st[1].ps[2];
    st_next[2].df = st[1].pf[0] + st[1].pf[1] + st[1].pf[2];

    st_next[3] = st[2];
    for (int i = 0; i < 3; i++) begin
      st_next[3].u[i] = UW'(rnd_frac(st[2].cu[i]));
    end
    st_next[3].ds = rnd_frac(st[2].ds);
    st_next[3].df = rnd_frac(st[2].df);

    st_next[4] = st[3];
    for (int i = 0; i < 3; i++) begin
      st_next[4].pe[i] = $signed(st[3].u[i]) * $signed(st[3].eye[i]);
    end

    st_next[5] = st[4];
    st_next[5].de = st[4].pe[0] + st[4].pe[1] + st[4].pe[2];

    st_next[6] = st[5];
    st_next[6].de = rnd_frac(st[5].de);

    // Column-major: element index is column times four plus row.
    st_next[7] = st[6];
    st_next[7].el[0]  = sat_word(TW'($signed(st[6].s[0])));
    st_next[7].el[1]  = sat_word(TW'($signed(st[6].u[0])));
    st_next[7].el[2]  = sat_word(TW'(0) - TW'($signed(st[6].f[0])));
    st_next[7].el[3]  = '0;
    st_next[7].el[4]  = sat_word(TW'($signed(st[6].s[1])));
    st_next[7].el[5]  = sat_word(TW'($signed(st[6].u[1])));
    st_next[7].el[6]  = sat_word(TW'(0) - TW'($signed(st[6].f[1])));
    st_next[7].el[7]  = '0;
    st_next[7].el[8]  = sat_word(TW'($signed(st[6].s[2])));
    st_next[7].el[9]  = sat_word(TW'($signed(st[6].u[2])));
    st_next[7].el[10] = sat_word(TW'(0) - TW'($signed(st[6].f[2])));
    st_next[7].el[11] = '0;
    st_next[7].el[12] = sat_word(TW'(0) - st[6].ds);
    st_next[7].el[13] = sat_word(TW'(0) - st[6].de);
    st_next[7].el[14] = sat_word(st[6].df);
    st_next[7].el[15] = ONE_FX;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NM-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 1; k <= NM; k++) begin
        st[k] <= st_next[k];
      end
    end
  end

  assign out_valid = vld[NM-1];
  assign mat       = st[NM].el;

endmodule

### rtl/lavm_ser.sv
// ----------------------------------------------------------------------------
// Element serializer
// Holds one finished matrix and sends it out one word per handshake.
// ----------------------------------------------------------------------------
`include "look_at_view_matrix_defines.svh"

module lavm_ser import lavm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [NEL-1:0][DW-1:0] mat,
  output logic                   element_valid,
  input  logic                   element_ready,
  output logic [IW-1:0]          element_index,
  output logic signed [DW-1:0]   element_value,
  output logic                   last_element
);

  localparam logic [IW-1:0] LAST_IDX = IW'(NEL - 1);

  logic [NEL-1:0][DW-1:0] hold;
  logic [IW-1:0]          cnt;
  logic                   busy;
  logic                   load;
  logic                   last;

  assign last     = (cnt == LAST_IDX);
  // A new matrix may load in the same cycle the final word leaves.
  assign in_ready = !busy || (element_ready && last);
  assign load     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy && element_ready) begin
      if (last) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hold <= mat;
    end
  end

  assign element_valid = busy;
  assign element_index = cnt;
  assign element_value = hold[cnt];
  assign last_element  = last;

  `LAVM_ASSERT_NEXT(a_load_first, load, busy && cnt == '0)
  `LAVM_ASSERT_NEXT(a_step, busy && element_ready && !last, busy && cnt == $past(cnt) + IW'(1))
  `LAVM_ASSERT_NEXT(a_drain, busy && element_ready && last && !load, !busy)

endmodule

### rtl/look_at_view_matrix.sv
// ----------------------------------------------------------------------------
// Look-at view matrix
// Builds a column-major 4x4 view matrix from eye, target and up vectors in
// signed fixed point and sends it out as sixteen words.
//
//   Channel | Handshake                    | Payload
//   item    | item_valid / item_ready      | eye_*, target_*, up_* (9 x 32 bits)
//   element | element_valid / element_ready| element_index, element_value,
//           |                              | last_element
//
// The path from item to first word runs through two normalize pipelines of
// NSH + MB + FRAC_BITS + 8 stages each, the side cross product, seven matrix
// stages and the serializer load. The output sends one word per cycle while
// element_ready is high, and new items enter while an earlier matrix is sent.
// Reset clears only valid bits and the serializer state; no clearing pass.
// A stalled output freezes the whole pipeline while its last stage is full.
// ----------------------------------------------------------------------------
module look_at_view_matrix import lavm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  logic signed [DW-1:0] eye_x,
  input  logic signed [DW-1:0] eye_y,
  input  logic signed [DW-1:0] eye_z,
  input  logic signed [DW-1:0] target_x,
  input  logic signed [DW-1:0] target_y,
  input  logic signed [DW-1:0] target_z,
  input  logic signed [DW-1:0] up_x,
  input  logic signed [DW-1:0] up_y,
  input  logic signed [DW-1:0] up_z,
  output logic                 element_valid,
  input  logic                 element_ready,
  output logic [IW-1:0]        element_index,
  output logic signed [DW-1:0] element_value,
  output logic                 last_element
);

  logic                   en;
  logic [2:0][VW-1:0]     dir;
  side_t                  side0;
  logic                   f_valid;
  logic [2:0][OW-1:0]     f_unit;
  side_t                  f_side;
  logic                   c_valid;
  logic [2:0][VW-1:0]     c_vec;
  side_t                  c_side;
  logic                   s_valid;
  logic [2:0][OW-1:0]     s_unit;
  side_t                  s_side;
  logic                   mat_valid;
  logic                   mat_ready;
  logic [NEL-1:0][DW-1:0] mat;

  assign dir[0] = VW'(target_x) - VW'(eye_x);
  assign dir[1] = VW'(target_y) - VW'(eye_y);
  assign dir[2] = VW'(target_z) - VW'(eye_z);
  assign side0.eye = {eye_z, eye_y, eye_x};
  assign side0.aux = {up_z, up_y, up_x};

  // All stages move together; they hold only when the finished matrix waits.
  assign en         = !mat_valid || mat_ready;
  assign item_ready = en;

  lavm_norm u_norm_f (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (item_valid),
    .vec      (dir),
    .in_side  (side0),
    .out_valid(f_valid),
    .unit     (f_unit),
    .out_side (f_side)
  );

  lavm_xf u_xf (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (f_valid),
    .f        (f_unit),
    .in_side  (f_side),
    .out_valid(c_valid),
    .vec      (c_vec),
    .out_side (c_side)
  );

  lavm_norm u_norm_s (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (c_valid),
    .vec      (c_vec),
    .in_side  (c_side),
    .out_valid(s_valid),
    .unit     (s_unit),
    .out_side (s_side)
  );

  lavm_mat u_mat (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_valid),
    .s        (s_unit),
    .in_side  (s_side),
    .out_valid(mat_valid),
    .mat      (mat)
  );

  lavm_ser u_ser (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (mat_valid),
    .in_ready     (mat_ready),
    .mat          (mat),
    .element_valid(element_valid),
    .element_ready(element_ready),
    .element_index(element_index),
    .element_value(element_value),
    .last_element (last_element)
  );

endmodule
